// ----- hw/rtl/tbsd_pkg.sv -----
package tbsd_pkg;

  // escape store geometry
  localparam int ESC_DEPTH = 32;
  localparam int ADDR_W    = $clog2(ESC_DEPTH);
  localparam int LEN_W     = $clog2(ESC_DEPTH + 1);

  // argument range
  localparam logic [15:0] ARG_MAX  = 16'hFFFF;
  localparam logic [15:0] PI_POINT = 16'h03C0;

  // control bytes
  localparam logic [7:0] CH_BEL = 8'd7;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_VT  = 8'd11;
  localparam logic [7:0] CH_FF  = 8'd12;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_ESC = 8'd27;
  localparam logic [7:0] CH_SP  = 8'd32;
  localparam logic [7:0] UTF_2  = 8'd192;
  localparam logic [7:0] UTF_3  = 8'd224;
  localparam logic [7:0] UTF_4  = 8'd240;

  // event codes
  localparam logic [5:0] ACT_CHAR    = 6'd0;
  localparam logic [5:0] ACT_BS      = 6'd1;
  localparam logic [5:0] ACT_TAB     = 6'd2;
  localparam logic [5:0] ACT_CR      = 6'd3;
  localparam logic [5:0] ACT_CHARSET = 6'd4;
  localparam logic [5:0] ACT_RESET   = 6'd5;
  localparam logic [5:0] ACT_SAVE    = 6'd6;
  localparam logic [5:0] ACT_RESTORE = 6'd7;
  localparam logic [5:0] ACT_UP      = 6'd8;
  localparam logic [5:0] ACT_DOWN    = 6'd9;
  localparam logic [5:0] ACT_RIGHT   = 6'd10;
  localparam logic [5:0] ACT_LEFT    = 6'd11;
  localparam logic [5:0] ACT_EL      = 6'd12;
  localparam logic [5:0] ACT_DCH     = 6'd13;
  localparam logic [5:0] ACT_ECH     = 6'd14;
  localparam logic [5:0] ACT_CUP     = 6'd15;
  localparam logic [5:0] ACT_HTS     = 6'd16;
  localparam logic [5:0] ACT_ED      = 6'd17;
  localparam logic [5:0] ACT_DL      = 6'd18;
  localparam logic [5:0] ACT_SD      = 6'd19;
  localparam logic [5:0] ACT_IL      = 6'd20;
  localparam logic [5:0] ACT_SGR     = 6'd21;
  localparam logic [5:0] ACT_HPA     = 6'd22;
  localparam logic [5:0] ACT_VPA     = 6'd23;
  localparam logic [5:0] ACT_REP     = 6'd24;
  localparam logic [5:0] ACT_TBC     = 6'd25;
  localparam logic [5:0] ACT_DECSET  = 6'd26;
  localparam logic [5:0] ACT_SM      = 6'd27;
  localparam logic [5:0] ACT_DECRST  = 6'd28;
  localparam logic [5:0] ACT_RM      = 6'd29;
  localparam logic [5:0] ACT_SOFT    = 6'd30;
  localparam logic [5:0] ACT_STBM    = 6'd31;
  localparam logic [5:0] ACT_ICH     = 6'd32;
  localparam logic [5:0] ACT_UPDATE  = 6'd33;

  typedef enum logic [1:0] {
    MODE_IDLE, MODE_ESC, MODE_UTF8, MODE_SKIP
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN_A, ST_SCAN_D, ST_ARG_A, ST_ARG_D,
    ST_REP_A, ST_REP_D, ST_DFLT, ST_UPD
  } state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  action;
    logic [15:0] value;
    logic        has_value;
    logic        last;
  } out_word_t;

  function automatic logic is_letter(input logic [7:0] b);
    logic [7:0] l;
    l = b | 8'h20;
    return (l >= "a") && (l <= "z");
  endfunction

  function automatic logic is_short_end(input logic [7:0] b);
    return b == "=" || b == ">" || b == "<" || b == "7" || b == "8" ||
           b == "|" || b == "}" || b == "~";
  endfunction

  function automatic logic is_dflt_one(input logic [7:0] b);
    return b == "A" || b == "B" || b == "C" || b == "D" || b == "G" || b == "M" ||
           b == "L" || b == "P" || b == "X" || b == "d" || b == "@";
  endfunction

endpackage

// ----- hw/rtl/terminal_byte_stream_decoder.sv -----
// Terminal byte stream decoder: one raw byte per input word, zero or more
// event words out, the final one of each byte flagged by last. Plain bytes,
// controls, UTF-8 bytes and bytes inside an escape sequence are decoded as
// they are taken. An escape sequence is kept in a 32-byte store with one write
// port and one registered read port. When a sequence that takes arguments
// closes, a sequencer walks the store to check the syntax, then walks it again
// to emit the arguments, or walks the stored bytes to replay the sequence as
// characters. An empty argument list emits one or two default words instead.
// Such a closing byte therefore holds the input until the sequencer is done,
// including any screen update word and any output stalls. Input is taken only
// while the sequencer is idle and the output register is free or being
// emptied. No clearing pass is needed after reset.
module terminal_byte_stream_decoder import tbsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  // parser state
  mode_t            mode_r, mode_nxt;
  logic [LEN_W-1:0] esc_len_r, esc_len_nxt;
  logic [7:0]       s1_r, s1_nxt, s2_r, s2_nxt, prev_r, prev_nxt;
  logic [15:0]      acc_r, acc_nxt;
  logic [1:0]       left_r, left_nxt;
  logic [2:0]       ulen_r, ulen_nxt;
  logic             pbo_r, pbo_nxt;

  // sequencer state
  state_t           st_r, st_nxt;
  logic [LEN_W-1:0] seq_len_r, seq_len_nxt, idx_r, idx_nxt, start_r, start_nxt;
  logic [LEN_W-1:0] nargs_r, nargs_nxt, cnt_r, cnt_nxt;
  logic             expect_r, expect_nxt;
  logic [15:0]      cur_r, cur_nxt;
  logic [5:0]       act_r, act_nxt;
  logic             upd_r, upd_nxt, two_r, two_nxt, dval_r, dval_nxt;

  // output register
  out_word_t        out_r, out_w;
  logic             out_valid_r, out_load, can_load, in_acc;

  // escape store
  logic [7:0]       mem [ESC_DEPTH];
  logic [7:0]       rd_data_r;
  logic             mem_we;

  assign can_load  = !out_valid_r || out_ready;
  assign in_ready  = (st_r == ST_IDLE) && can_load;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // store write on accepted escape sequence bytes, registered read at the sequencer index
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[esc_len_r[ADDR_W-1:0]] <= in_word.data_byte;
    end
    rd_data_r <= mem[idx_r[ADDR_W-1:0]];
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      esc_len_r   <= '0;
      acc_r       <= '0;
      left_r      <= '0;
      ulen_r      <= '0;
      pbo_r       <= 1'b0;
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      esc_len_r <= esc_len_nxt;
      acc_r     <= acc_nxt;
      left_r    <= left_nxt;
      ulen_r    <= ulen_nxt;
      pbo_r     <= pbo_nxt;
      st_r      <= st_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (out_load) begin
      out_r <= out_w;
    end
    s1_r      <= s1_nxt;
    s2_r      <= s2_nxt;
    prev_r    <= prev_nxt;
    seq_len_r <= seq_len_nxt;
    idx_r     <= idx_nxt;
    start_r   <= start_nxt;
    nargs_r   <= nargs_nxt;
    cnt_r     <= cnt_nxt;
    expect_r  <= expect_nxt;
    cur_r     <= cur_nxt;
    act_r     <= act_nxt;
    upd_r     <= upd_nxt;
    two_r     <= two_nxt;
    dval_r    <= dval_nxt;
  end

  // byte decode and sequencer
  always_comb begin
    logic [7:0]       b, s1, s2, c;
    logic             pe, done, closed, imm, args, upd, pbo_tmp, bad, is_end, dig;
    logic [5:0]       imm_act, args_act;
    logic [15:0]      imm_val, acc_n, cur_n;
    logic             imm_has;
    logic [1:0]       left_n;
    logic [LEN_W-1:0] len_new, start, nargs_n;
    logic [19:0]      prod;

    mode_nxt    = mode_r;
    esc_len_nxt = esc_len_r;
    s1_nxt      = s1_r;
    s2_nxt      = s2_r;
    prev_nxt    = prev_r;
    acc_nxt     = acc_r;
    left_nxt    = left_r;
    ulen_nxt    = ulen_r;
    pbo_nxt     = pbo_r;
    st_nxt      = st_r;
    seq_len_nxt = seq_len_r;
    idx_nxt     = idx_r;
    start_nxt   = start_r;
    nargs_nxt   = nargs_r;
    cnt_nxt     = cnt_r;
    expect_nxt  = expect_r;
    cur_nxt     = cur_r;
    act_nxt     = act_r;
    upd_nxt     = upd_r;
    two_nxt     = two_r;
    dval_nxt    = dval_r;
    out_load    = 1'b0;
    out_w       = '0;
    mem_we      = 1'b0;

    b        = in_word.data_byte;
    pe       = in_word.packet_end;
    s1       = s1_r;
    s2       = s2_r;
    c        = rd_data_r;
    done     = 1'b0;
    closed   = 1'b0;
    imm      = 1'b0;
    args     = 1'b0;
    imm_act  = ACT_CHAR;
    args_act = ACT_CHAR;
    imm_val  = '0;
    imm_has  = 1'b0;
    acc_n    = '0;
    left_n   = '0;
    len_new  = esc_len_r + LEN_W'(1);
    start    = LEN_W'(2);
    nargs_n  = nargs_r;
    bad      = 1'b0;
    is_end   = (idx_r == seq_len_r - LEN_W'(2));
    dig      = (c >= "0") && (c <= "9");
    prod     = {4'd0, cur_r} * 20'd10 + {12'd0, c - "0"};
    cur_n    = (prod > {4'd0, ARG_MAX}) ? ARG_MAX : prod[15:0];
    upd      = 1'b0;
    pbo_tmp  = pbo_r;

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (mode_r)
            MODE_ESC: begin
              if (esc_len_r < LEN_W'(ESC_DEPTH)) begin
                mem_we      = 1'b1;
                s1          = (len_new == LEN_W'(2)) ? b : s1_r;
                s2          = (len_new == LEN_W'(3)) ? b : s2_r;
                s1_nxt      = s1;
                s2_nxt      = s2;
                prev_nxt    = b;
                esc_len_nxt = len_new;
                if (s1 == "]") begin
                  done = (b == CH_BEL);
                end else begin
                  done = ((len_new == LEN_W'(2)) && is_short_end(s1)) || is_letter(b) ||
                         (b == "@") || ((len_new == LEN_W'(3)) && (s1 == "("));
                end
                if (done) begin
                  closed = 1'b1;
                  if (s1 == "]") begin
                    imm = 1'b0;
                  end else if (s1 == "(") begin
                    imm = 1'b1; imm_act = ACT_CHARSET; imm_val = {8'd0, s2}; imm_has = 1'b1;
                  end else if (s1 == "c") begin
                    imm = 1'b1; imm_act = ACT_RESET;
                  end else begin
                    case (b)
                      "7": begin imm = 1'b1; imm_act = ACT_SAVE; end
                      "8": begin imm = 1'b1; imm_act = ACT_RESTORE; end
                      "A": begin args = 1'b1; args_act = ACT_UP; end
                      "B": begin args = 1'b1; args_act = ACT_DOWN; end
                      "C": begin args = 1'b1; args_act = ACT_RIGHT; end
                      "D": begin args = 1'b1; args_act = ACT_LEFT; end
                      "K": begin args = (s1 == "["); args_act = ACT_EL; end
                      "P": begin args = 1'b1; args_act = ACT_DCH; end
                      "X": begin args = (len_new != LEN_W'(2)); args_act = ACT_ECH; end
                      "H": begin
                        if (s1 == "[") begin
                          args = 1'b1; args_act = ACT_CUP;
                        end else begin
                          imm = 1'b1; imm_act = ACT_HTS;
                        end
                      end
                      "J": begin
                        args = (len_new != LEN_W'(2)) && (s2 != "?"); args_act = ACT_ED;
                      end
                      "M": begin
                        if (s1 == "[") begin
                          args = 1'b1; args_act = ACT_DL;
                        end else begin
                          imm = 1'b1; imm_act = ACT_SD;
                        end
                      end
                      "L": begin args = 1'b1; args_act = ACT_IL; end
                      "m": begin args = (s1 == "["); args_act = ACT_SGR; end
                      "G": begin args = (s1 != "%"); args_act = ACT_HPA; end
                      "d": begin args = 1'b1; args_act = ACT_VPA; end
                      "b": begin args = 1'b1; args_act = ACT_REP; end
                      "g": begin args = 1'b1; args_act = ACT_TBC; end
                      "h": begin
                        args = 1'b1; args_act = (s2 == "?") ? ACT_DECSET : ACT_SM;
                      end
                      "l": begin
                        args = 1'b1; args_act = (s2 == "?") ? ACT_DECRST : ACT_RM;
                      end
                      "p": begin
                        imm = (len_new > LEN_W'(3)) && (s2 == "!"); imm_act = ACT_SOFT;
                      end
                      "r": begin
                        args = (prev_r != "$") && (s2 != "?"); args_act = ACT_STBM;
                      end
                      "s": begin imm = (len_new == LEN_W'(3)); imm_act = ACT_SAVE; end
                      "@": begin args = (s1 != "%"); args_act = ACT_ICH; end
                      default: begin imm = 1'b0; end
                    endcase
                  end
                end
              end else begin
                mode_nxt = MODE_SKIP;
                done     = (s1_r == "]") ? (b == CH_BEL) : (is_letter(b) || (b == "@"));
                closed   = done;
              end
            end
            MODE_SKIP: begin
              done   = (s1_r == "]") ? (b == CH_BEL) : (is_letter(b) || (b == "@"));
              closed = done;
            end
            MODE_UTF8: begin
              acc_n  = {acc_r[9:0], b[5:0]};
              left_n = (left_r != 2'd0) ? left_r - 2'd1 : 2'd0;
              if (left_n == 2'd0) begin
                imm      = 1'b1;
                imm_val  = (ulen_r == 3'd4) ? PI_POINT : acc_n;
                imm_has  = 1'b1;
                acc_nxt  = '0;
                ulen_nxt = '0;
                left_nxt = '0;
                closed   = 1'b1;
              end else begin
                acc_nxt  = acc_n;
                left_nxt = left_n;
              end
            end
            default: begin
              if (b == CH_ESC) begin
                mem_we      = 1'b1;
                esc_len_nxt = LEN_W'(1);
                mode_nxt    = MODE_ESC;
                s1_nxt      = '0;
                s2_nxt      = '0;
                prev_nxt    = b;
              end else if (b == CH_BS) begin
                imm = 1'b1; imm_act = ACT_BS;
              end else if (b == CH_TAB) begin
                imm = 1'b1; imm_act = ACT_TAB;
              end else if (b == CH_CR) begin
                imm = 1'b1; imm_act = ACT_CR;
              end else if (b < UTF_2) begin
                imm     = 1'b1;
                imm_has = 1'b1;
                if ((b < CH_SP) && (b != CH_LF)) begin
                  imm_val = ((b == CH_VT) || (b == CH_FF)) ? {8'd0, CH_LF} : 16'd0;
                end else begin
                  imm_val = {8'd0, b};
                end
              end else begin
                mode_nxt = MODE_UTF8;
                if (b < UTF_3) begin
                  ulen_nxt = 3'd2; left_nxt = 2'd1; acc_nxt = {11'd0, b[4:0]};
                end else if (b < UTF_4) begin
                  ulen_nxt = 3'd3; left_nxt = 2'd2; acc_nxt = {12'd0, b[3:0]};
                end else begin
                  ulen_nxt = 3'd4; left_nxt = 2'd3; acc_nxt = '0;
                end
              end
            end
          endcase

          // closing a sequence also clears the open-packet flag
          if (closed) begin
            mode_nxt    = MODE_IDLE;
            esc_len_nxt = '0;
            pbo_tmp     = 1'b0;
          end
          upd     = pe && !pbo_tmp;
          pbo_nxt = pe ? (mode_nxt != MODE_IDLE) : pbo_tmp;

          if (args) begin
            start       = (s2 == "?") ? LEN_W'(3) : LEN_W'(2);
            seq_len_nxt = len_new;
            start_nxt   = start;
            act_nxt     = args_act;
            upd_nxt     = upd;
            idx_nxt     = '0;
            if (start == len_new - LEN_W'(1)) begin
              st_nxt   = ST_DFLT;
              two_nxt  = (b == "H") || (b == "r");
              dval_nxt = (b == "H") || is_dflt_one(b);
            end else if (start >= len_new) begin
              st_nxt = ST_REP_A;
            end else begin
              st_nxt     = ST_SCAN_A;
              idx_nxt    = start;
              expect_nxt = 1'b1;
              nargs_nxt  = '0;
            end
          end else if (imm) begin
            out_load = 1'b1;
            out_w    = '{action: imm_act, value: imm_val, has_value: imm_has, last: !upd};
            if (upd) begin
              st_nxt = ST_UPD;
            end
          end else if (upd) begin
            out_load = 1'b1;
            out_w    = '{action: ACT_UPDATE, value: 16'd0, has_value: 1'b0, last: 1'b1};
          end
        end
      end
      ST_SCAN_A: begin
        st_nxt = ST_SCAN_D;
      end
      // syntax check and argument count
      ST_SCAN_D: begin
        if (c == ";") begin
          bad        = expect_r;
          nargs_n    = nargs_r + LEN_W'(1);
          expect_nxt = 1'b1;
        end else if (dig) begin
          expect_nxt = 1'b0;
        end else begin
          bad = 1'b1;
        end
        if (bad) begin
          st_nxt  = ST_REP_A;
          idx_nxt = '0;
        end else if (is_end) begin
          nargs_nxt = nargs_n + LEN_W'(!expect_nxt);
          st_nxt    = ST_ARG_A;
          idx_nxt   = start_r;
          cur_nxt   = '0;
          cnt_nxt   = '0;
        end else begin
          nargs_nxt = nargs_n;
          idx_nxt   = idx_r + LEN_W'(1);
          st_nxt    = ST_SCAN_A;
        end
      end
      ST_ARG_A: begin
        st_nxt = ST_ARG_D;
      end
      // decimal accumulation, one word per argument
      ST_ARG_D: begin
        if ((c == ";") || is_end) begin
          if (can_load) begin
            out_load = 1'b1;
            out_w    = '{action: act_r, value: (c == ";") ? cur_r : cur_n, has_value: 1'b1,
                         last: (cnt_r + LEN_W'(1) == nargs_r) && !upd_r};
            cnt_nxt  = cnt_r + LEN_W'(1);
            cur_nxt  = '0;
            if (is_end) begin
              st_nxt = upd_r ? ST_UPD : ST_IDLE;
            end else begin
              idx_nxt = idx_r + LEN_W'(1);
              st_nxt  = ST_ARG_A;
            end
          end
        end else begin
          cur_nxt = cur_n;
          idx_nxt = idx_r + LEN_W'(1);
          st_nxt  = ST_ARG_A;
        end
      end
      ST_REP_A: begin
        st_nxt = ST_REP_D;
      end
      // raw replay of the stored sequence
      ST_REP_D: begin
        if (can_load) begin
          out_load = 1'b1;
          out_w    = '{action: ACT_CHAR, value: {8'd0, c}, has_value: 1'b1,
                       last: (idx_r == seq_len_r - LEN_W'(1)) && !upd_r};
          if (idx_r == seq_len_r - LEN_W'(1)) begin
            st_nxt = upd_r ? ST_UPD : ST_IDLE;
          end else begin
            idx_nxt = idx_r + LEN_W'(1);
            st_nxt  = ST_REP_A;
          end
        end
      end
      // default argument values
      ST_DFLT: begin
        if (can_load) begin
          out_load = 1'b1;
          out_w    = '{action: act_r, value: {15'd0, dval_r}, has_value: 1'b1,
                       last: (!two_r || (idx_r != '0)) && !upd_r};
          if (!two_r || (idx_r != '0)) begin
            st_nxt = upd_r ? ST_UPD : ST_IDLE;
          end else begin
            idx_nxt = LEN_W'(1);
          end
        end
      end
      ST_UPD: begin
        if (can_load) begin
          out_load = 1'b1;
          out_w    = '{action: ACT_UPDATE, value: 16'd0, has_value: 1'b0, last: 1'b1};
          st_nxt   = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/tbsd_checker.sv -----
module tbsd_checker import tbsd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // no byte is taken while a result waits without being taken
  a_in_gate: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("byte taken while output register full");

  // screen update always closes the events of its byte
  a_upd_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.action == ACT_UPDATE |-> out_word.last && !out_word.has_value)
    else $error("screen update not last");

  // commands without a value carry zero
  a_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.has_value |-> out_word.value == 16'd0 &&
      out_word.action <= ACT_UPDATE)
    else $error("bad command word");

endmodule

bind terminal_byte_stream_decoder tbsd_checker u_tbsd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_word  (in_word),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_word (out_word)
);
